>>> hw/rtl/rwla_pkg.sv
package rwla_pkg;

  // Waiter queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OFF_W       = CNT_W + 1;

  // Field widths
  localparam int AGENT_W  = 4;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;
  localparam int SHARED_W = 5;

  // Shared holder count saturates here
  localparam logic [SHARED_W-1:0] SHARED_MAX = {SHARED_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_ACQ_SH = 3'd0,
    OP_ACQ_EX = 3'd1,
    OP_REL_SH = 3'd2,
    OP_REL_EX = 3'd3,
    OP_CANCEL = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED     = 3'd0,
    ST_QUEUED      = 3'd1,
    ST_RELEASED    = 3'd2,
    ST_CANCELLED   = 3'd3,
    ST_CANCEL_MISS = 3'd4,
    ST_QUEUE_FULL  = 3'd5,
    ST_RELEASE_ERR = 3'd6
  } status_t;

  // One waiter: mode flag and agent id
  typedef struct packed {
    logic               excl;
    logic [AGENT_W-1:0] agent;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> hw/rtl/rwla_ram.sv
module rwla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/reader_writer_lock_arbiter_unit.sv
// Channel  | Ports                                       | Direction
// ---------+---------------------------------------------+----------
// in       | in_valid, in_ready, in_opcode, in_requester | request in
// out      | out_valid, out_ready, out_status,           | result out
//          | out_agent, out_last                         |
//
// One item at a time: in_ready is high only while the sequencer is idle.
// Acquires and releases that leave the lock held pass through execute and
// flush; a release that frees the lock also runs a wake pass that grants waiters.
// A cancel scans and shifts the queue one entry per cycle through the RAM
// port; a hit then re-reads the head and runs the wake pass, a miss flushes.
// Each result waits for a free output register, so out_ready stalls hold
// the sequencer. Synchronous active-low reset empties the lock and the queue.
module reader_writer_lock_arbiter_unit
  import rwla_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [AGENT_W-1:0]  in_requester,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [AGENT_W-1:0]  out_agent,
  output logic                out_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SRD, S_SCMP, S_SHIFT, S_PRE, S_WAKE, S_FLUSH
  } state_t;

  localparam logic [OFF_W:0] SUM_DEPTH = (OFF_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // Queue offset from head to RAM address, with one wrap correction
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                            input logic [OFF_W-1:0] off);
    logic [OFF_W:0] sum;
    sum = (OFF_W + 1)'(head) + {1'b0, off};
    if (sum >= SUM_DEPTH) begin
      sum = sum - SUM_DEPTH;
    end
    return sum[PTR_W-1:0];
  endfunction

  state_t                state_r, state_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [AGENT_W-1:0]    agent_r, agent_nxt;
  logic                  excl_r, excl_nxt;
  logic [SHARED_W-1:0]   shared_r, shared_nxt;
  logic [CNT_W-1:0]      wwait_r, wwait_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  status_t               pend_status_r, pend_status_nxt;
  logic [AGENT_W-1:0]    pend_agent_r, pend_agent_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [AGENT_W-1:0]    out_agent_r, out_agent_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  wr_en;
  logic [PTR_W-1:0]      wr_addr;
  logic [ENTRY_W-1:0]    wr_data;
  logic [PTR_W-1:0]      rd_addr;
  logic [ENTRY_W-1:0]    rd_data;
  entry_t                rd_entry;
  logic                  slot_free;
  logic [OFF_W-1:0]      idx_ext, idx_p1, idx_p2, cnt_ext;

  rwla_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_entry  = entry_t'(rd_data);
  assign slot_free = !out_valid_r || out_ready;
  assign idx_ext   = {1'b0, idx_r};
  assign idx_p1    = idx_ext + OFF_W'(1);
  assign idx_p2    = idx_ext + OFF_W'(2);
  assign cnt_ext   = {1'b0, count_r};

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_agent  = out_agent_r;
  assign out_last   = out_last_r;

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    agent_nxt       = agent_r;
    excl_nxt        = excl_r;
    shared_nxt      = shared_r;
    wwait_nxt       = wwait_r;
    count_nxt       = count_r;
    head_nxt        = head_r;
    idx_nxt         = idx_r;
    pend_status_nxt = pend_status_r;
    pend_agent_nxt  = pend_agent_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_agent_nxt   = out_agent_r;
    out_last_nxt    = out_last_r;
    wr_en           = 1'b0;
    wr_addr         = phys(head_r, cnt_ext);
    wr_data         = {1'b0, agent_r};
    rd_addr         = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          agent_nxt = in_requester;
          if (in_opcode <= OP_CANCEL) begin
            state_nxt = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        pend_agent_nxt = agent_r;
        state_nxt      = S_FLUSH;
        case (op_r)
          OP_ACQ_SH: begin
            if (!excl_r && wwait_r == '0 && shared_r != SHARED_MAX) begin
              shared_nxt      = shared_r + 1'b1;
              pend_status_nxt = ST_GRANTED;
            end else if (count_r != CNT_FULL) begin
              wr_en           = 1'b1;
              wr_data         = {1'b0, agent_r};
              count_nxt       = count_r + 1'b1;
              pend_status_nxt = ST_QUEUED;
            end else begin
              pend_status_nxt = ST_QUEUE_FULL;
            end
          end
          OP_ACQ_EX: begin
            if (!excl_r && shared_r == '0) begin
              excl_nxt        = 1'b1;
              pend_status_nxt = ST_GRANTED;
            end else if (count_r != CNT_FULL) begin
              wr_en           = 1'b1;
              wr_data         = {1'b1, agent_r};
              count_nxt       = count_r + 1'b1;
              wwait_nxt       = wwait_r + 1'b1;
              pend_status_nxt = ST_QUEUED;
            end else begin
              pend_status_nxt = ST_QUEUE_FULL;
            end
          end
          OP_REL_SH: begin
            if (shared_r == '0) begin
              pend_status_nxt = ST_RELEASE_ERR;
            end else begin
              shared_nxt      = shared_r - 1'b1;
              pend_status_nxt = ST_RELEASED;
              if (shared_r == SHARED_W'(1) && !excl_r) begin
                state_nxt = S_WAKE;
              end
            end
          end
          OP_REL_EX: begin
            if (!excl_r) begin
              pend_status_nxt = ST_RELEASE_ERR;
            end else begin
              excl_nxt        = 1'b0;
              pend_status_nxt = ST_RELEASED;
              state_nxt       = S_WAKE;
            end
          end
          OP_CANCEL: begin
            idx_nxt = '0;
            if (count_r == '0) begin
              pend_status_nxt = ST_CANCEL_MISS;
            end else begin
              state_nxt = S_SRD;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      // Prime the search with the head entry
      S_SRD: begin
        rd_addr   = phys(head_r, idx_ext);
        state_nxt = S_SCMP;
      end

      // Compare one entry per cycle, next read already in flight
      S_SCMP: begin
        rd_addr = phys(head_r, idx_p1);
        if (rd_entry.agent == agent_r) begin
          if (rd_entry.excl && wwait_r != '0) begin
            wwait_nxt = wwait_r - 1'b1;
          end
          pend_status_nxt = ST_CANCELLED;
          state_nxt       = S_SHIFT;
        end else if (idx_p1 >= cnt_ext) begin
          pend_status_nxt = ST_CANCEL_MISS;
          state_nxt       = S_FLUSH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // Close the gap: entry j+1 moves to j
      S_SHIFT: begin
        rd_addr = phys(head_r, idx_p2);
        if (idx_p1 < cnt_ext) begin
          wr_en   = 1'b1;
          wr_addr = phys(head_r, idx_ext);
          wr_data = rd_data;
          idx_nxt = idx_r + 1'b1;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_PRE;
        end
      end

      // Re-read the head after the shift
      S_PRE: begin
        state_nxt = S_WAKE;
      end

      // Wake pass: one grant per cycle from the head while the output register is free
      S_WAKE: begin
        if (count_r == '0 || excl_r) begin
          state_nxt = S_FLUSH;
        end else if (rd_entry.excl) begin
          if (shared_r != '0) begin
            state_nxt = S_FLUSH;
          end else if (slot_free) begin
            head_nxt        = phys(head_r, OFF_W'(1));
            count_nxt       = count_r - 1'b1;
            excl_nxt        = 1'b1;
            if (wwait_r != '0) begin
              wwait_nxt = wwait_r - 1'b1;
            end
            out_valid_nxt   = 1'b1;
            out_status_nxt  = pend_status_r;
            out_agent_nxt   = pend_agent_r;
            out_last_nxt    = 1'b0;
            pend_status_nxt = ST_GRANTED;
            pend_agent_nxt  = rd_entry.agent;
            state_nxt       = S_FLUSH;
          end
        end else if (shared_r != SHARED_MAX) begin
          if (slot_free) begin
            head_nxt        = phys(head_r, OFF_W'(1));
            count_nxt       = count_r - 1'b1;
            shared_nxt      = shared_r + 1'b1;
            out_valid_nxt   = 1'b1;
            out_status_nxt  = pend_status_r;
            out_agent_nxt   = pend_agent_r;
            out_last_nxt    = 1'b0;
            pend_status_nxt = ST_GRANTED;
            pend_agent_nxt  = rd_entry.agent;
          end
        end else begin
          state_nxt = S_FLUSH;
        end
      end

      // Final result of the item
      S_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_agent_nxt  = pend_agent_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Outside the queue walk the read port follows the head
    if (state_r != S_SRD && state_r != S_SCMP && state_r != S_SHIFT) begin
      rd_addr = head_nxt;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      excl_r      <= 1'b0;
      shared_r    <= '0;
      wwait_r     <= '0;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      excl_r      <= excl_nxt;
      shared_r    <= shared_nxt;
      wwait_r     <= wwait_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r          <= op_nxt;
    agent_r       <= agent_nxt;
    idx_r         <= idx_nxt;
    pend_status_r <= pend_status_nxt;
    pend_agent_r  <= pend_agent_nxt;
    out_status_r  <= out_status_nxt;
    out_agent_r   <= out_agent_nxt;
    out_last_r    <= out_last_nxt;
  end

endmodule

>>> hw/rtl/rwla_checker.sv
module rwla_checker
  import rwla_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [OP_W-1:0]     in_opcode,
  input logic [AGENT_W-1:0]  in_requester,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [AGENT_W-1:0]  out_agent,
  input logic                out_last
);

  // A real request leaves the block busy in the cycle after it is accepted
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode <= OP_CANCEL) |=> !in_ready)
    else $error("ready right after a request item");

  // Unknown opcodes are dropped without leaving idle
  a_ignore_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode > OP_CANCEL) |=> in_ready)
    else $error("unknown opcode left idle");

  // Only the answer and wake grants precede the last result
  a_nonlast_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> (out_status == ST_GRANTED ||
                                out_status == ST_RELEASED ||
                                out_status == ST_CANCELLED))
    else $error("non-final result with a final-only status");

  // No new item while non-final results of the current one are outstanding
  a_nonlast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("ready while an item is still producing results");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_agent) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind reader_writer_lock_arbiter_unit rwla_checker u_rwla_checker (.*);
